>>> sv/srf_pkg.sv
// shared constants and types for the serial register file slave
// no dependencies
package srf_pkg;

  localparam int STORE_DEPTH_DEF = 12;

  localparam logic [7:0] CMD_READ      = 8'h23;
  localparam logic [7:0] CMD_WRITE     = 8'h2A;
  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  // store access requested by the command decoder for one item
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_req_t;

endpackage

>>> sv/srf_ram.sv
// generic single write port ram with registered read
// no dependencies
module srf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 12
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> sv/srf_ctrl.sv
// command decoder: phase, byte timeout counter and timeout register
// depends on srf_pkg
module srf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             op,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  output srf_pkg::mem_req_t req
);
  import srf_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_RD_ADDR = 2'd1;
  localparam logic [1:0] PH_WR_ADDR = 2'd2;
  localparam logic [1:0] PH_WR_DATA = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] timeout_r;
  logic [7:0] cnt_inc;

  assign cnt_inc = wait_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    held_nxt  = held_r;
    req       = '0;
    req.data  = rx_byte;
    if (acc) begin
      if (op) begin
        if (phase_r != PH_IDLE) begin
          wait_nxt = cnt_inc;
          if (cnt_inc >= timeout_r) begin
            phase_nxt = PH_IDLE;
            wait_nxt  = 8'd0;
          end
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (rx_byte == CMD_READ) begin
              phase_nxt = PH_RD_ADDR;
              wait_nxt  = 8'd0;
            end else if (rx_byte == CMD_WRITE) begin
              phase_nxt = PH_WR_ADDR;
              wait_nxt  = 8'd0;
            end
          end
          PH_RD_ADDR: begin
            req.rd_en = 1'b1;
            req.addr  = rx_byte;
            phase_nxt = PH_IDLE;
            wait_nxt  = 8'd0;
          end
          PH_WR_ADDR: begin
            held_nxt  = rx_byte;
            phase_nxt = PH_WR_DATA;
            wait_nxt  = 8'd0;
          end
          default: begin
            req.wr_en = 1'b1;
            req.addr  = held_r;
            phase_nxt = PH_IDLE;
            wait_nxt  = 8'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wait_r    <= 8'd0;
      held_r    <= 8'd0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      held_r  <= held_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // counter only runs while a command is open
  a_idle_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> wait_r == 8'd0)
    else $error("wait count nonzero while idle");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en))
    else $error("read and write requested by one item");

  a_write_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> $past(phase_nxt) == PH_WR_DATA || phase_r == PH_WR_DATA)
    else $error("write issued outside write data phase");

endmodule

>>> sv/serial_register_file_slave.sv
// serial register file slave: read address item gives its result via the
// registered store read, then the output register; one item per cycle
// is accepted, limited only when the output register and read stage both stall
// synchronous active-low reset clears control state, timeout (to 100) and the
// per-entry valid bits, so every store entry reads as zero at once after reset
// depends on srf_pkg, srf_ram, srf_ctrl
module serial_register_file_slave #(
  parameter int STORE_DEPTH = srf_pkg::STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_bad_address,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import srf_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  mem_req_t         req;
  logic             acc;
  logic             in_range;
  logic [AW-1:0]    idx;
  logic [7:0]       rdata_r;
  logic             ent_vld_r [STORE_DEPTH];
  logic             pend_r;
  logic             pend_bad_r;
  logic             pend_vld_r;
  logic             out_valid_r;
  logic [7:0]       out_tx_r;
  logic             out_bad_r;
  logic             out_free;
  logic             pend_adv;

  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign pend_adv  = pend_r && out_free;
  assign in_ready  = !pend_r || out_free;

  assign in_range = {1'b0, req.addr} < 9'(STORE_DEPTH);
  assign idx      = req.addr[AW-1:0];

  srf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .op       (in_op),
    .rx_byte  (in_rx_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .req      (req)
  );

  srf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (req.wr_en && in_range),
    .waddr   (idx),
    .wdata   (req.data),
    .re      (req.rd_en && in_range),
    .raddr   (idx),
    .rdata_r (rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        ent_vld_r[i] <= 1'b0;
      end
    end else if (req.wr_en && in_range) begin
      ent_vld_r[idx] <= 1'b1;
    end
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        pend_r <= 1'b1;
      end else if (pend_adv) begin
        pend_r <= 1'b0;
      end
      if (pend_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      pend_bad_r <= !in_range;
      pend_vld_r <= in_range && ent_vld_r[idx];
    end
    if (pend_adv) begin
      out_tx_r  <= (pend_bad_r || !pend_vld_r) ? 8'd0 : rdata_r;
      out_bad_r <= pend_bad_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tx_byte     = out_tx_r;
  assign out_bad_address = out_bad_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("item accepted while read stage is stalled");

  a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |=> pend_r)
    else $error("read item lost before read stage");

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_tx_r == 8'd0)
    else $error("out of range read returned nonzero data");

endmodule

>>> tb/srf_reply_checker.sv
`timescale 1ns / 1ps
// reply checker for the serial register file slave: tracks the command decoder,
// the timeout register and the byte store, and compares every reply item
// depends on srf_pkg
module srf_reply_checker #(
  parameter int STORE_DEPTH = srf_pkg::STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_tx_byte,
  input  logic       out_bad_address,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         replies_due_count,
  output int         replies_checked
);
  import srf_pkg::*;

  typedef enum logic [1:0] {
    CMD_IDLE,
    AWAIT_RD_ADDR,
    AWAIT_WR_ADDR,
    AWAIT_WR_DATA
  } cmd_phase_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       bad_address;
  } reply_t;

  cmd_phase_t cmd_phase;
  logic [7:0] timeout_ticks;
  logic [7:0] write_addr;
  logic [7:0] ticks_waited;
  logic [7:0] file_mirror [STORE_DEPTH];
  reply_t     replies_due [$];

  initial begin
    fail_count        = 0;
    replies_due_count = 0;
    replies_checked   = 0;
  end

  task automatic flag_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  task automatic predict_item(input logic is_tick, input logic [7:0] b);
    reply_t r;
    if (is_tick) begin
      if (cmd_phase != CMD_IDLE) begin
        ticks_waited = ticks_waited + 8'd1;
        if (ticks_waited >= timeout_ticks) begin
          cmd_phase    = CMD_IDLE;
          ticks_waited = '0;
        end
      end
    end else begin
      case (cmd_phase)
        CMD_IDLE: begin
          if (b == CMD_READ) begin
            cmd_phase    = AWAIT_RD_ADDR;
            ticks_waited = '0;
          end else if (b == CMD_WRITE) begin
            cmd_phase    = AWAIT_WR_ADDR;
            ticks_waited = '0;
          end
        end
        AWAIT_RD_ADDR: begin
          if (b < STORE_DEPTH) begin
            r.tx_byte     = file_mirror[b];
            r.bad_address = 1'b0;
          end else begin
            r.tx_byte     = 8'h00;
            r.bad_address = 1'b1;
          end
          replies_due.push_back(r);
          cmd_phase    = CMD_IDLE;
          ticks_waited = '0;
        end
        AWAIT_WR_ADDR: begin
          write_addr   = b;
          cmd_phase    = AWAIT_WR_DATA;
          ticks_waited = '0;
        end
        default: begin
          if (write_addr < STORE_DEPTH) begin
            file_mirror[write_addr] = b;
          end
          cmd_phase    = CMD_IDLE;
          ticks_waited = '0;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      timeout_ticks = TIMEOUT_RESET;
      cmd_phase     = CMD_IDLE;
      write_addr    = '0;
      ticks_waited  = '0;
      foreach (file_mirror[i]) begin
        file_mirror[i] = '0;
      end
      replies_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        replies_checked++;
        if (replies_due.size() == 0) begin
          flag_failure($sformatf("unexpected reply item: tx_byte=%h bad_address=%b",
                                 out_tx_byte, out_bad_address));
        end else begin
          want = replies_due.pop_front();
          if (out_tx_byte !== want.tx_byte || out_bad_address !== want.bad_address) begin
            flag_failure($sformatf({"reply mismatch: expected tx_byte=%h bad_address=%b,",
                                    " got tx_byte=%h bad_address=%b"},
                                   want.tx_byte, want.bad_address,
                                   out_tx_byte, out_bad_address));
          end
        end
      end
      // an item in the same cycle as a timeout write still sees the old value
      if (in_valid && in_ready) begin
        predict_item(in_op, in_rx_byte);
      end
      if (cfg_valid && cfg_ready) begin
        timeout_ticks = cfg_data;
      end
    end
    replies_due_count = replies_due.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// top of the serial register file slave regression: clock, reset, item and
// timeout register stimulus, reply-side stalls and the verdict
// depends on srf_pkg, serial_register_file_slave and srf_reply_checker
module testbench;
  import srf_pkg::*;

  localparam int   DEPTH        = STORE_DEPTH_DEF;
  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   CYCLE_LIMIT  = 600000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_op;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_tx_byte;
  logic       out_bad_address;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  int fail_count;
  int replies_due_count;
  int replies_checked;

  int         items_sent  = 0;
  int         ticks_sent  = 0;
  int         cfg_writes  = 0;
  int         cycles      = 0;
  int         stall_left  = 0;
  int         mode_left   = 0;
  int         drain_wait;
  bit         steady_send = 1'b0;
  bit         steady_recv = 1'b0;
  logic [7:0] cur_timeout = TIMEOUT_RESET;

  always #5 clk = ~clk;

  serial_register_file_slave #(
    .STORE_DEPTH(DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_byte    (out_tx_byte),
    .out_bad_address(out_bad_address),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  srf_reply_checker #(
    .STORE_DEPTH(DEPTH)
  ) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_byte      (out_tx_byte),
    .out_bad_address  (out_bad_address),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .replies_due_count(replies_due_count),
    .replies_checked  (replies_checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("serial_register_file_slave regression: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int random_gap();
    if ($urandom_range(0, 99) < 75) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // reply side stalls, with stretches of steady ready
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        steady_recv = ($urandom_range(0, 3) == 0);
        mode_left   = $urandom_range(20, 200);
      end
      mode_left--;
      if (!steady_recv && $urandom_range(0, 2) == 0) begin
        stall_left = random_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!steady_send && $urandom_range(0, 99) >= 60) begin
      gap = random_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == OP_TICK) begin
      ticks_sent++;
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic set_timeout(input logic [7:0] t);
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_timeout = t;
    cfg_writes++;
  endtask

  // ticks while a command byte is awaited: none, a few, one short of the
  // timeout, or exactly the timeout
  task automatic tick_wait();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (r >= 60 && r < 80) begin
      n = $urandom_range(1, 3);
    end else if (r >= 80) begin
      if (cur_timeout > 40 && $urandom_range(0, 7) != 0) begin
        n = $urandom_range(1, 3);
      end else if (r < 90) begin
        n = (cur_timeout > 1) ? cur_timeout - 1 : 0;
      end else begin
        n = (cur_timeout == 0) ? 1 : cur_timeout;
      end
    end
    send_ticks(n);
  endtask

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return 8'($urandom_range(0, DEPTH - 1));
    end else if (r < 90) begin
      return 8'($urandom_range(DEPTH, 255));
    end else if (r < 95) begin
      return 8'(DEPTH);
    end
    return 8'hFF;
  endfunction

  task automatic random_phase(input logic [7:0] t, input int budget);
    int first;
    int r;
    set_timeout(t);
    steady_send = ($urandom_range(0, 2) == 0);
    first = items_sent;
    while (items_sent - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        send_item(OP_BYTE, CMD_READ);
        tick_wait();
        send_item(OP_BYTE, pick_addr());
      end else if (r < 80) begin
        send_item(OP_BYTE, CMD_WRITE);
        tick_wait();
        send_item(OP_BYTE, pick_addr());
        tick_wait();
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 88) begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 94) begin
        send_ticks($urandom_range(1, 3));
      end else begin
        // command with ticks that cut it short if the timeout is at most 40; the rest of it arrives as later items
        send_item(OP_BYTE, r[0] ? CMD_READ : CMD_WRITE);
        send_ticks(cur_timeout == 0 ? 1 : (cur_timeout > 40 ? 3 : cur_timeout));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_BYTE;
    in_rx_byte = 8'h00;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // store after reset, extremes of address and data, out of range access
    send_item(OP_BYTE, CMD_READ);
    send_item(OP_BYTE, 8'd0);
    send_item(OP_BYTE, CMD_WRITE);
    send_item(OP_BYTE, 8'd0);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CMD_WRITE);
    send_item(OP_BYTE, 8'(DEPTH - 1));
    send_item(OP_BYTE, 8'hA5);
    send_item(OP_BYTE, CMD_WRITE);
    send_item(OP_BYTE, 8'(DEPTH));
    send_item(OP_BYTE, 8'h5A);
    send_item(OP_BYTE, CMD_READ);
    send_item(OP_BYTE, 8'd0);
    send_item(OP_BYTE, CMD_READ);
    send_item(OP_BYTE, 8'(DEPTH - 1));
    send_item(OP_BYTE, CMD_READ);
    send_item(OP_BYTE, 8'(DEPTH));
    send_item(OP_BYTE, CMD_READ);
    send_item(OP_BYTE, 8'hFF);
    // idle noise and idle ticks
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, 8'hFF);
    // ticks below the timeout restart per awaited byte
    send_item(OP_BYTE, CMD_WRITE);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'd3);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, CMD_READ);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'd3);

    random_phase(8'd1, 140);
    random_phase(8'd255, 150);
    random_phase(8'd0, 100);
    random_phase(8'($urandom_range(2, 30)), 150);
    random_phase(8'($urandom_range(31, 254)), 100);

    @(negedge clk);
    in_valid <= 1'b0;
    drain_wait = 0;
    while (replies_due_count != 0 && drain_wait < 5000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d items (%0d ticks) and %0d reply items across %0d timeout settings",
             items_sent, ticks_sent, replies_checked, cfg_writes + 1);
    $display("timeouts 0, 1, 255 and the reset value, in and out of range addresses, %0d failures",
             fail_count);
    if (replies_due_count == 0 && fail_count == 0) begin
      $display("serial_register_file_slave regression: pass");
    end else begin
      $display("serial_register_file_slave regression: fail");
    end
    $finish;
  end

endmodule
